// File: hdl/snmt_pkg.sv
package snmt_pkg;

    // default table size
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_DELETE  = 2'd1,
        FUNC_XLATE_IN  = 2'd2,
        FUNC_XLATE_OUT = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        STAT_DONE      = 3'd0,
        STAT_NO_MATCH  = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_MISMATCH  = 3'd4,
        STAT_PASSED    = 3'd5
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [7:0]  protocol;
        logic [31:0] lan_ip;
        logic [15:0] lan_port;
        logic [31:0] wan_ip;
        logic [15:0] wan_port;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] mapped_ip;
        logic [15:0] mapped_port;
    } t_rsp;

    // address and port of one side of a mapping
    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
    } t_pair;

    // first-hit flags carried along the cell chain
    typedef struct packed {
        logic pub;
        logic prv;
        logic free;
    } t_hits;

endpackage

// File: hdl/snmt_cell.sv
module snmt_cell #(
    parameter int IDX_W    = $clog2(snmt_pkg::TABLE_ENTRIES_DEF),
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  snmt_pkg::t_req      i_cmd,
    input  logic                i_tok_vld,
    input  snmt_pkg::t_hits     i_tok_hit,
    input  logic [IDX_W-1:0]    i_tok_pub_idx,
    input  logic [IDX_W-1:0]    i_tok_prv_idx,
    input  logic [IDX_W-1:0]    i_tok_free_idx,
    input  snmt_pkg::t_pair     i_tok_data,
    output logic                o_tok_vld,
    output snmt_pkg::t_hits     o_tok_hit,
    output logic [IDX_W-1:0]    o_tok_pub_idx,
    output logic [IDX_W-1:0]    o_tok_prv_idx,
    output logic [IDX_W-1:0]    o_tok_free_idx,
    output snmt_pkg::t_pair     o_tok_data,
    input  logic                i_wr_en,
    input  logic                i_clr_en,
    input  logic [IDX_W-1:0]    i_sel_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // entry held by this cell
    logic            r_valid;
    snmt_pkg::t_pair r_prv;
    snmt_pkg::t_pair r_pub;

    // token register toward the next cell
    logic             r_tok_vld;
    snmt_pkg::t_hits  r_tok_hit;
    logic [IDX_W-1:0] r_tok_pub_idx;
    logic [IDX_W-1:0] r_tok_prv_idx;
    logic [IDX_W-1:0] r_tok_free_idx;
    snmt_pkg::t_pair  r_tok_data;

    snmt_pkg::t_pair  key_pub;
    snmt_pkg::t_pair  key_prv;
    logic             pub_m;
    logic             prv_m;
    logic             sel_me;

    snmt_pkg::t_hits  n_tok_hit;
    logic [IDX_W-1:0] n_tok_pub_idx;
    logic [IDX_W-1:0] n_tok_prv_idx;
    logic [IDX_W-1:0] n_tok_free_idx;
    snmt_pkg::t_pair  n_tok_data;

    assign key_pub = '{ip: i_cmd.wan_ip, port: i_cmd.wan_port};
    assign key_prv = '{ip: i_cmd.lan_ip, port: i_cmd.lan_port};
    assign pub_m   = r_valid && (r_pub == key_pub);
    assign prv_m   = r_valid && (r_prv == key_prv);
    assign sel_me  = (i_sel_idx == MY_IDX);

    always_comb begin
        n_tok_hit      = i_tok_hit;
        n_tok_pub_idx  = i_tok_pub_idx;
        n_tok_prv_idx  = i_tok_prv_idx;
        n_tok_free_idx = i_tok_free_idx;
        n_tok_data     = i_tok_data;
        if (!i_tok_hit.pub && pub_m) begin
            n_tok_hit.pub = 1'b1;
            n_tok_pub_idx = MY_IDX;
            if (i_cmd.func == snmt_pkg::FUNC_XLATE_IN) begin
                n_tok_data = r_prv;
            end
        end
        if (!i_tok_hit.prv && prv_m) begin
            n_tok_hit.prv = 1'b1;
            n_tok_prv_idx = MY_IDX;
            if (i_cmd.func == snmt_pkg::FUNC_XLATE_OUT) begin
                n_tok_data = r_pub;
            end
        end
        if (!i_tok_hit.free && !r_valid) begin
            n_tok_hit.free = 1'b1;
            n_tok_free_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
            if (i_wr_en && sel_me) begin
                r_valid <= 1'b1;
            end else if (i_clr_en && sel_me) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && sel_me) begin
            r_prv <= key_prv;
            r_pub <= key_pub;
        end
        if (i_tok_vld) begin
            r_tok_hit      <= n_tok_hit;
            r_tok_pub_idx  <= n_tok_pub_idx;
            r_tok_prv_idx  <= n_tok_prv_idx;
            r_tok_free_idx <= n_tok_free_idx;
            r_tok_data     <= n_tok_data;
        end
    end

    assign o_tok_vld      = r_tok_vld;
    assign o_tok_hit      = r_tok_hit;
    assign o_tok_pub_idx  = r_tok_pub_idx;
    assign o_tok_prv_idx  = r_tok_prv_idx;
    assign o_tok_free_idx = r_tok_free_idx;
    assign o_tok_data     = r_tok_data;

endmodule

// File: hdl/static_nat_mapping_table.sv
// Static NAT mapping table. One command is taken when start is high and busy is low; its
// single result appears on o_rsp for exactly one cycle with o_valid high, and the receiver
// cannot stall it, so it must capture the result in that cycle. A translate whose protocol
// is neither TCP nor UDP answers in the cycle after the transfer. Every other command runs a
// search token down a chain of TABLE_ENTRIES cells, one cell per cycle, and answers
// once the token has left the last cell; busy drops with the result, so no new command is
// taken while a search is running. The length of the cell chain sets how long busy stays
// high. Table updates for add and delete land with the result, as busy drops.
module static_nat_mapping_table #(
    parameter int TABLE_ENTRIES = snmt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  snmt_pkg::t_req  i_req,
    output logic            o_valid,
    output snmt_pkg::t_rsp  o_rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state          r_state;
    t_state          n_state;
    snmt_pkg::t_req  r_cmd;        // command held steady for the whole scan
    logic            r_inject;     // token enters the first cell
    logic            n_inject;
    logic            r_out_vld;
    logic            n_out_vld;
    snmt_pkg::t_rsp  r_rsp;
    snmt_pkg::t_rsp  n_rsp;

    logic            accept;
    logic            proto_ok;

    // token wires between cells, index k feeds cell k
    logic                tok_vld      [TABLE_ENTRIES+1];
    snmt_pkg::t_hits     tok_hit      [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]    tok_pub_idx  [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]    tok_prv_idx  [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]    tok_free_idx [TABLE_ENTRIES+1];
    snmt_pkg::t_pair     tok_data     [TABLE_ENTRIES+1];

    // table update broadcast to every cell
    logic                wr_en;
    logic                clr_en;
    logic [IDX_W-1:0]    sel_idx;

    logic                tok_done;
    snmt_pkg::t_hits     fin_hit;

    assign accept   = start && !busy;
    assign proto_ok = (i_req.protocol == snmt_pkg::PROTO_TCP) ||
                      (i_req.protocol == snmt_pkg::PROTO_UDP);

    // head of the chain: empty token
    assign tok_vld[0]      = r_inject;
    assign tok_hit[0]      = '0;
    assign tok_pub_idx[0]  = '0;
    assign tok_prv_idx[0]  = '0;
    assign tok_free_idx[0] = '0;
    assign tok_data[0]     = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        snmt_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (r_cmd),
            .i_tok_vld      (tok_vld[g]),
            .i_tok_hit      (tok_hit[g]),
            .i_tok_pub_idx  (tok_pub_idx[g]),
            .i_tok_prv_idx  (tok_prv_idx[g]),
            .i_tok_free_idx (tok_free_idx[g]),
            .i_tok_data     (tok_data[g]),
            .o_tok_vld      (tok_vld[g+1]),
            .o_tok_hit      (tok_hit[g+1]),
            .o_tok_pub_idx  (tok_pub_idx[g+1]),
            .o_tok_prv_idx  (tok_prv_idx[g+1]),
            .o_tok_free_idx (tok_free_idx[g+1]),
            .o_tok_data     (tok_data[g+1]),
            .i_wr_en        (wr_en),
            .i_clr_en       (clr_en),
            .i_sel_idx      (sel_idx)
        );
    end

    // token leaving the last cell carries the full search result
    assign tok_done = (r_state == ST_SCAN) && tok_vld[TABLE_ENTRIES];
    assign fin_hit  = tok_hit[TABLE_ENTRIES];

    always_comb begin
        n_state   = r_state;
        n_inject  = 1'b0;
        n_out_vld = 1'b0;
        n_rsp     = r_rsp;
        wr_en     = 1'b0;
        clr_en    = 1'b0;
        sel_idx   = tok_free_idx[TABLE_ENTRIES];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((i_req.func == snmt_pkg::FUNC_XLATE_IN ||
                         i_req.func == snmt_pkg::FUNC_XLATE_OUT) && !proto_ok) begin
                        // non tcp/udp passes through with no lookup
                        n_out_vld = 1'b1;
                        n_rsp     = '{status: snmt_pkg::STAT_PASSED,
                                      mapped_ip: '0, mapped_port: '0};
                    end else begin
                        n_inject = 1'b1;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tok_done) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                    n_rsp     = '{status: snmt_pkg::STAT_DONE,
                                  mapped_ip: '0, mapped_port: '0};
                    unique case (r_cmd.func)
                        snmt_pkg::FUNC_ADD: begin
                            if (fin_hit.pub || fin_hit.prv) begin
                                n_rsp.status = snmt_pkg::STAT_DUPLICATE;
                            end else if (fin_hit.free) begin
                                // lowest free entry gets the new mapping
                                wr_en = 1'b1;
                            end else begin
                                n_rsp.status = snmt_pkg::STAT_FULL;
                            end
                        end
                        snmt_pkg::FUNC_DELETE: begin
                            sel_idx = tok_pub_idx[TABLE_ENTRIES];
                            if (!fin_hit.pub && !fin_hit.prv) begin
                                n_rsp.status = snmt_pkg::STAT_NO_MATCH;
                            end else if (fin_hit.pub && fin_hit.prv &&
                                         tok_pub_idx[TABLE_ENTRIES] ==
                                         tok_prv_idx[TABLE_ENTRIES]) begin
                                // both pairs name the same entry
                                clr_en = 1'b1;
                            end else begin
                                n_rsp.status = snmt_pkg::STAT_MISMATCH;
                            end
                        end
                        snmt_pkg::FUNC_XLATE_IN: begin
                            if (fin_hit.pub) begin
                                n_rsp.mapped_ip   = tok_data[TABLE_ENTRIES].ip;
                                n_rsp.mapped_port = tok_data[TABLE_ENTRIES].port;
                            end else begin
                                n_rsp.status = snmt_pkg::STAT_NO_MATCH;
                            end
                        end
                        snmt_pkg::FUNC_XLATE_OUT: begin
                            if (fin_hit.prv) begin
                                n_rsp.mapped_ip   = tok_data[TABLE_ENTRIES].ip;
                                n_rsp.mapped_port = tok_data[TABLE_ENTRIES].port;
                            end else begin
                                n_rsp.status = snmt_pkg::STAT_NO_MATCH;
                            end
                        end
                        default: begin
                            n_rsp.status = snmt_pkg::STAT_NO_MATCH;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_inject  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inject  <= n_inject;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_req;
        end
        r_rsp <= n_rsp;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

endmodule

// File: verif/static_nat_mapping_table_tb.sv
`timescale 1ns / 100ps

module static_nat_mapping_table_tb;
    import snmt_pkg::*;

    localparam int N_ENT       = TABLE_ENTRIES_DEF;
    localparam int N_RANDOM    = 1280;  // spread over three sender idling phases
    localparam int STALL_LIMIT = 2000;  // quiet cycles before the run is declared hung

    // one directed command, with its result typed in when it is obvious
    typedef struct {
        t_req  req;
        bit    typed;
        t_rsp  rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    // shadow of the mapping table
    bit    ent_live [N_ENT];
    t_pair ent_prv  [N_ENT];
    t_pair ent_pub  [N_ENT];

    t_rsp  rsp_due[$];      // results owed by the block, oldest first
    t_row  dir_rows[$];
    t_rsp  want;
    int    n_bad        = 0;
    int    stall_cycles = 0;
    int    idle_pct     = 0;

    // random mix control: fill the table, sit at full for a while, then drain it
    bit    filling   = 1'b1;
    int    full_hold = 20;

    static_nat_mapping_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // lowest valid entry whose public (by_pub) or private pair equals p, else -1
    function automatic int find_entry(bit by_pub, t_pair p);
        for (int i = 0; i < N_ENT; i++) begin
            if (ent_live[i] && (by_pub ? ent_pub[i] : ent_prv[i]) == p)
                return i;
        end
        return -1;
    endfunction

    // applies one command to the shadow table and returns the result it owes
    function automatic t_rsp nat_table_op(t_req r);
        t_rsp  rsp;
        t_pair prv;
        t_pair pub;
        int    a;
        int    b;
        rsp = '{STAT_DONE, 32'd0, 16'd0};
        prv = '{r.lan_ip, r.lan_port};
        pub = '{r.wan_ip, r.wan_port};
        a   = find_entry(1'b1, pub);
        b   = find_entry(1'b0, prv);
        case (r.func)
            FUNC_ADD: begin
                if (a >= 0 || b >= 0) begin
                    rsp.status = STAT_DUPLICATE;
                end else begin
                    rsp.status = STAT_FULL;
                    for (int i = 0; i < N_ENT; i++) begin
                        if (!ent_live[i]) begin
                            ent_live[i] = 1'b1;
                            ent_prv[i]  = prv;
                            ent_pub[i]  = pub;
                            rsp.status  = STAT_DONE;
                            break;
                        end
                    end
                end
            end
            FUNC_DELETE: begin
                if (a < 0 && b < 0) begin
                    rsp.status = STAT_NO_MATCH;
                end else if (a >= 0 && a == b) begin
                    ent_live[a] = 1'b0;
                end else begin
                    rsp.status = STAT_MISMATCH;
                end
            end
            default: begin
                if (r.protocol != PROTO_TCP && r.protocol != PROTO_UDP) begin
                    rsp.status = STAT_PASSED;
                end else if (r.func == FUNC_XLATE_IN) begin
                    if (a < 0) rsp.status = STAT_NO_MATCH;
                    else {rsp.mapped_ip, rsp.mapped_port} = ent_prv[a];
                end else begin
                    if (b < 0) rsp.status = STAT_NO_MATCH;
                    else {rsp.mapped_ip, rsp.mapped_port} = ent_pub[b];
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        foreach (ent_live[i]) n += ent_live[i];
        return n;
    endfunction

    function automatic int pick_live();
        int idx[$];
        foreach (ent_live[i]) if (ent_live[i]) idx.push_back(i);
        if (idx.size() == 0) return -1;
        return idx[$urandom_range(idx.size() - 1)];
    endfunction

    // random pair, now and then with an all-zero or all-one field
    function automatic t_pair rand_pair();
        t_pair p;
        p.ip   = $urandom;
        p.port = 16'($urandom);
        case ($urandom_range(15))
            0: p.ip = '0;
            1: p.ip = '1;
            2: p.port = '0;
            3: p.port = '1;
            default: ;
        endcase
        return p;
    endfunction

    function automatic void row(t_func f, logic [7:0] proto,
                                logic [31:0] v_ip, logic [15:0] v_port,
                                logic [31:0] b_ip, logic [15:0] b_port,
                                bit typed = 1'b0, t_status st = STAT_DONE,
                                logic [31:0] m_ip = '0, logic [15:0] m_port = '0);
        t_req r;
        r = '{f, proto, v_ip, v_port, b_ip, b_port};
        dir_rows.push_back('{r, typed, '{st, m_ip, m_port}});
    endfunction

    // random command: mostly well-formed traffic against live mappings
    task automatic next_random(output t_req r);
        int    n;
        int    k;
        int    e;
        int    o;
        t_pair prv;
        t_pair pub;
        n = live_count();
        if (filling && n == N_ENT) begin
            if (full_hold == 0) filling = 1'b0;
            else full_hold--;
        end else if (!filling && n <= 4) begin
            filling   = 1'b1;
            full_hold = $urandom_range(10, 30);
        end
        prv = rand_pair();
        pub = rand_pair();
        e   = pick_live();
        o   = pick_live();
        r.protocol = 8'($urandom);
        k = $urandom_range(99);
        if (k < (filling ? 50 : 10)) begin
            // add: fresh pairs, or one side already mapped
            r.func = FUNC_ADD;
            k = $urandom_range(99);
            if (e >= 0 && k < 15) prv = ent_prv[e];
            else if (e >= 0 && k < 30) pub = ent_pub[e];
        end else if (k < (filling ? 60 : 55)) begin
            // delete: consistent, crossed, one-sided or unknown
            r.func = FUNC_DELETE;
            k = $urandom_range(99);
            if (e >= 0) begin
                if (k < 60) begin
                    prv = ent_prv[e];
                    pub = ent_pub[e];
                end else if (k < 75) begin
                    prv = ent_prv[e];
                    pub = ent_pub[o];
                end else if (k < 80) begin
                    prv = ent_prv[e];
                end else if (k < 85) begin
                    pub = ent_pub[e];
                end
            end
        end else begin
            r.func = $urandom_range(1) ? FUNC_XLATE_IN : FUNC_XLATE_OUT;
            if ($urandom_range(99) < 80)
                r.protocol = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
            if (e >= 0 && $urandom_range(99) < 75) begin
                if (r.func == FUNC_XLATE_IN) pub = ent_pub[e];
                else prv = ent_prv[e];
            end
        end
        {r.lan_ip, r.lan_port} = prv;
        {r.wan_ip, r.wan_port} = pub;
    endtask

    // drive one command and hold it until the block takes it; start stays high
    // afterwards so back-to-back commands need no gap between them
    task automatic send(t_req r, bit typed, t_rsp fixed_rsp);
        t_rsp guess;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        // busy is read before this edge's updates land: low here means transfer
        while (busy) @(posedge i_clk);
        guess = nat_table_op(r);
        rsp_due.push_back(typed ? fixed_rsp : guess);
    endtask

    // sender holds off until every owed result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (rsp_due.size() != 0) @(posedge i_clk);
    endtask

    // result checker and hang watchdog; results cannot be stalled, so each
    // strobe is compared on the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (rsp_due.size() == 0) begin
                    $error("unexpected result: status %0d ip %h port %h",
                           o_rsp.status, o_rsp.mapped_ip, o_rsp.mapped_port);
                    n_bad++;
                end else begin
                    want = rsp_due.pop_front();
                    if (o_rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_rsp.status);
                        n_bad++;
                    end
                    if (o_rsp.mapped_ip !== want.mapped_ip) begin
                        $error("mapped_ip: expected %h, got %h",
                               want.mapped_ip, o_rsp.mapped_ip);
                        n_bad++;
                    end
                    if (o_rsp.mapped_port !== want.mapped_port) begin
                        $error("mapped_port: expected %h, got %h",
                               want.mapped_port, o_rsp.mapped_port);
                        n_bad++;
                    end
                end
            end
            if (o_valid || (start && !busy)) begin
                stall_cycles <= 0;
            end else if (stall_cycles == STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        t_req r;

        // empty table: every lookup misses
        row(FUNC_XLATE_IN,  PROTO_TCP, '0, '0, '0, '0, 1'b1, STAT_NO_MATCH);
        row(FUNC_XLATE_OUT, PROTO_UDP, '1, '1, '1, '1, 1'b1, STAT_NO_MATCH);
        row(FUNC_DELETE,    8'h00,     '0, '0, '0, '0, 1'b1, STAT_NO_MATCH);
        // other protocols pass without a lookup
        row(FUNC_XLATE_IN,  8'h00, '0, '0, '0, '0, 1'b1, STAT_PASSED);
        row(FUNC_XLATE_OUT, 8'hff, '1, '1, '1, '1, 1'b1, STAT_PASSED);
        // extreme pairs mapped crosswise; protocol is ignored on add
        row(FUNC_ADD, 8'hff, '0, '0, '1, '1, 1'b1, STAT_DONE);
        row(FUNC_ADD, 8'h00, '1, '1, '0, '0, 1'b1, STAT_DONE);
        row(FUNC_XLATE_IN,  PROTO_TCP, 32'h1234_5678, 16'h9abc, '1, '1,
            1'b1, STAT_DONE, '0, '0);
        row(FUNC_XLATE_OUT, PROTO_UDP, '1, '1, 32'h5555_aaaa, 16'h5a5a,
            1'b1, STAT_DONE, '0, '0);
        row(FUNC_XLATE_OUT, PROTO_TCP, '0, '0, '0, '0, 1'b1, STAT_DONE, '1, '1);
        row(FUNC_XLATE_IN,  PROTO_UDP, '0, '0, '0, '0, 1'b1, STAT_DONE, '1, '1);
        // add with either side already mapped
        row(FUNC_ADD, PROTO_TCP, '0, '0, 32'hc633_6401, 16'd80, 1'b1, STAT_DUPLICATE);
        row(FUNC_ADD, PROTO_UDP, 32'h0a00_0001, 16'd1234, '0, '0, 1'b1, STAT_DUPLICATE);
        // delete whose pairs hit different entries, or only one side hits
        row(FUNC_DELETE, PROTO_TCP, '0, '0, '0, '0, 1'b1, STAT_MISMATCH);
        row(FUNC_DELETE, PROTO_UDP, '0, '0, 32'hc633_6401, 16'd80, 1'b1, STAT_MISMATCH);
        // key is present but the protocol is not translated
        row(FUNC_XLATE_IN, 8'd7, '0, '0, '1, '1, 1'b1, STAT_PASSED);
        // consistent delete frees the lowest slot, which the next add reuses
        row(FUNC_DELETE,   8'h00,     '0, '0, '1, '1, 1'b1, STAT_DONE);
        row(FUNC_XLATE_IN, PROTO_TCP, '0, '0, '1, '1, 1'b1, STAT_NO_MATCH);
        row(FUNC_ADD, 8'h5a, 32'h0a00_0001, 16'd1234, 32'hc633_6401, 16'd80);
        row(FUNC_XLATE_OUT, PROTO_TCP, 32'h0a00_0001, 16'd1234, '0, '0);
        row(FUNC_XLATE_IN,  PROTO_UDP, 32'h7fff_ffff, 16'h8000, 32'hc633_6401, 16'd80);
        row(FUNC_XLATE_OUT, PROTO_UDP, 32'h8000_0000, 16'h7fff, '0, '0);
        row(FUNC_DELETE, PROTO_TCP, 32'h0a00_0001, 16'd1234, 32'hc633_6401, 16'd80,
            1'b1, STAT_DONE);
        row(FUNC_DELETE, PROTO_UDP, 32'h0a00_0001, 16'd1234, 32'hc633_6401, 16'd80,
            1'b1, STAT_NO_MATCH);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 9;
        foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        wait_drained();

        // random traffic: sender idles lightly, then heavily, then not at all;
        // each phase ends with the sender waiting for every owed result
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 9 : (ph == 1) ? 77 : 0;
            repeat (N_RANDOM / 3) begin
                next_random(r);
                send(r, 1'b0, '0);
            end
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (N_ENT + 8) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
